// ===== src/pih_pkg.sv =====
// ----------------------------------------------------------------------------
// pih_pkg
// Shared types, sizes and the key hash for the pointer intern hash table.
// ----------------------------------------------------------------------------
package pih_pkg;

  localparam int INIT_EXP   = 9;
  localparam int MAX_EXP    = 12;
  localparam int MAP_DEPTH  = 1 << MAX_EXP;
  localparam int LIST_DEPTH = 3 << (MAX_EXP - 3);
  localparam int SLOT_W     = MAX_EXP;
  localparam int LIST_W     = $clog2(LIST_DEPTH);
  localparam int EXP_W      = 5;
  localparam int IDX_W      = 11;
  localparam int KEY_W      = 64;
  localparam int SLOT_DW    = KEY_W + IDX_W;

  // Result codes
  typedef enum logic [1:0] {
    OUT_FOUND = 2'd0,
    OUT_NEW   = 2'd1,
    OUT_NULL  = 2'd2,
    OUT_FULL  = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    ST_CLEAR,    // zero the map
    ST_IDLE,
    ST_HASH1,    // first multiply
    ST_HASH2,    // second multiply
    ST_PROBE,    // issue a slot read
    ST_CHECK,    // compare read data
    ST_RH_READ,  // rehash: read stored key
    ST_RH_WAIT,
    ST_RESULT
  } state_t;

  // Hash stage helpers: the two multiplies sit in separate cycles.
  function automatic logic [31:0] hash_pre(input logic [63:0] k);
    logic [31:0] x;
    x = k[31:0] ^ k[63:32];
    return x ^ (x >> 16);
  endfunction

  function automatic logic [31:0] hash_mid(input logic [31:0] x);
    logic [31:0] y;
    y = x * 32'h21f0aaad;
    return y ^ (y >> 15);
  endfunction

  function automatic logic [31:0] hash_post(input logic [31:0] x);
    logic [31:0] y;
    y = x * 32'hd35a2d97;
    return y ^ (y >> 15);
  endfunction

endpackage

// ===== src/pih_ram.sv =====
// ----------------------------------------------------------------------------
// pih_ram
// Generic single-port-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module pih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/pointer_intern_hash_table.sv =====
// ----------------------------------------------------------------------------
// pointer_intern_hash_table
// Interns 64-bit keys into dense indices using a double-hashed slot map.
// ----------------------------------------------------------------------------
// Channel | Signals                      | Direction
// in      | in_valid, in_stall, lookup_key | in
// out     | out_valid, out_stall, entry_index, outcome | out
//
// One transaction at a time: after the accepting edge, the hash states ST_HASH1
// and ST_HASH2, a slot read issue state, a compare per probed slot (registered
// slot RAM data), then the result state. A null key goes straight to the result.
// An insert reaching the load limit triggers a rehash: a map clear, then per
// stored key a list read, a wait, the hash states and a read issue, plus a
// compare per probed slot.
// After reset the map is cleared, all 2^MAX_EXP = 4096 slots; no input taken.
// The result register holds while out_stall is high; in_stall stays high.
// ----------------------------------------------------------------------------
module pointer_intern_hash_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pih_pkg::KEY_W-1:0]  lookup_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pih_pkg::IDX_W-1:0]  entry_index,
  output logic [1:0]                 outcome
);
  import pih_pkg::*;

  state_t state, state_next;

  logic [KEY_W-1:0]  key;
  logic [31:0]       hv;
  logic [SLOT_W-1:0] pos, step;
  logic [SLOT_W:0]   nprobe;
  logic [EXP_W-1:0]  size_exp;
  logic [IDX_W-1:0]  entry_count;
  logic              full_flag;
  logic              rehash;      // busy reinserting stored keys
  logic [IDX_W-1:0]  rh_idx;
  logic [SLOT_W:0]   clr_addr;

  // Slot RAM
  logic               s_we;
  logic [SLOT_W-1:0]  s_waddr, s_raddr;
  logic [SLOT_DW-1:0] s_wdata, s_rdata;
  // Stored key list
  logic               l_we;
  logic [LIST_W-1:0]  l_waddr, l_raddr;
  logic [KEY_W-1:0]   l_rdata;

  pih_ram #(.WIDTH(SLOT_DW), .DEPTH(MAP_DEPTH)) u_slots (
    .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
    .rd_addr(s_raddr), .rd_data(s_rdata)
  );

  pih_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_list (
    .clk(clk), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(key),
    .rd_addr(l_raddr), .rd_data(l_rdata)
  );

  logic [SLOT_W-1:0] mask;
  logic [SLOT_W-1:0] pos_next;
  logic [KEY_W-1:0]  slot_key;
  logic [IDX_W-1:0]  slot_idx;
  logic [IDX_W-1:0]  limit;
  logic [31:0]       hash_final;
  logic              hit_empty, hit_key;

  assign mask       = SLOT_W'((32'd1 << size_exp) - 32'd1);
  assign pos_next   = (pos + step) & mask;
  assign slot_key   = s_rdata[SLOT_DW-1:IDX_W];
  assign slot_idx   = s_rdata[IDX_W-1:0];
  assign limit      = IDX_W'(32'd3 << (size_exp - 5'd3));
  assign hash_final = hash_post(hv);
  assign hit_empty  = (slot_key == '0);
  assign hit_key    = (slot_key == key);

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_RESULT);

  // Next state and memory controls
  always_comb begin
    state_next = state;
    s_we    = 1'b0;
    s_waddr = pos;
    s_wdata = {key, rh_idx};
    s_raddr = pos_next;
    l_we    = 1'b0;
    l_waddr = entry_count[LIST_W-1:0];
    l_raddr = rh_idx[LIST_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_addr[SLOT_W-1:0];
        s_wdata = '0;
        if (clr_addr == SLOT_W'(MAP_DEPTH - 1)) begin
          state_next = (rehash && rh_idx < entry_count) ? ST_RH_READ : ST_IDLE;
          if (rehash && !(rh_idx < entry_count)) state_next = ST_RESULT;
        end
      end
      ST_IDLE:    if (in_valid) state_next = (lookup_key == '0) ? ST_RESULT : ST_HASH1;
      ST_HASH1:   state_next = ST_HASH2;
      ST_HASH2:   state_next = ST_PROBE;
      ST_PROBE:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (hit_empty || hit_key) begin
          if (rehash) begin
            s_we    = 1'b1;
            s_wdata = {key, rh_idx};
            state_next = (rh_idx + 1'b1 < entry_count) ? ST_RH_READ : ST_RESULT;
          end else if (hit_key) begin
            state_next = ST_RESULT;
          end else if (full_flag || entry_count >= IDX_W'(LIST_DEPTH)) begin
            state_next = ST_RESULT;
          end else begin
            s_we    = 1'b1;
            s_wdata = {key, entry_count};
            l_we    = 1'b1;
            if (entry_count + 1'b1 == limit && size_exp < EXP_W'(MAX_EXP))
              state_next = ST_CLEAR;
            else
              state_next = ST_RESULT;
          end
        end else if (nprobe == (SLOT_W+1)'(32'd1 << size_exp)) begin
          state_next = rehash ? ((rh_idx + 1'b1 < entry_count) ? ST_RH_READ : ST_RESULT)
                              : ST_RESULT;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_RH_READ: state_next = ST_RH_WAIT;
      ST_RH_WAIT: state_next = ST_HASH1;
      ST_RESULT:  if (!out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      size_exp    <= EXP_W'(INIT_EXP);
      entry_count <= '0;
      full_flag   <= 1'b0;
      rehash      <= 1'b0;
      rh_idx      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: begin
          if (in_valid) begin
            key <= lookup_key;
            hv  <= hash_pre(lookup_key);
            entry_index <= '0;
            outcome     <= OUT_NULL;
          end
        end
        ST_HASH1: hv <= hash_mid(hv);
        ST_HASH2: begin
          hv     <= hash_final;
          step   <= SLOT_W'((hash_final >> (6'd32 - 6'(size_exp))) | 32'd1);
          pos    <= SLOT_W'(hash_final) & mask;
          nprobe <= '0;
        end
        ST_PROBE: begin
          pos    <= pos_next;
          nprobe <= nprobe + 1'b1;
        end
        ST_CHECK: begin
          if (hit_empty || hit_key) begin
            if (rehash) begin
              rh_idx <= rh_idx + 1'b1;
              if (!(rh_idx + 1'b1 < entry_count)) rehash <= 1'b0;
            end else if (hit_key) begin
              entry_index <= slot_idx;
              outcome     <= OUT_FOUND;
            end else if (full_flag || entry_count >= IDX_W'(LIST_DEPTH)) begin
              full_flag <= 1'b1;
              outcome   <= OUT_FULL;
            end else begin
              entry_count <= entry_count + 1'b1;
              entry_index <= entry_count;
              outcome     <= OUT_NEW;
              if (entry_count + 1'b1 == limit) begin
                if (size_exp < EXP_W'(MAX_EXP)) begin
                  size_exp <= size_exp + 1'b1;
                  rehash   <= 1'b1;
                  rh_idx   <= '0;
                  clr_addr <= '0;
                end else begin
                  full_flag <= 1'b1;
                end
              end
            end
          end else if (nprobe == (SLOT_W+1)'(32'd1 << size_exp)) begin
            if (rehash) begin
              rh_idx <= rh_idx + 1'b1;
              if (!(rh_idx + 1'b1 < entry_count)) rehash <= 1'b0;
            end else begin
              outcome <= OUT_FULL;
            end
          end else begin
            pos    <= pos_next;
            nprobe <= nprobe + 1'b1;
          end
        end
        ST_RH_WAIT: begin
          key <= l_rdata;
          hv  <= hash_pre(l_rdata);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/tb_pointer_intern_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_pointer_intern_hash_table
// Drives keys into the intern table and checks every returned index and
// outcome against a behavioral model of the hashed map, its growth and fill.
// ----------------------------------------------------------------------------
module tb_pointer_intern_hash_table;
  timeunit 1ns;
  timeprecision 1ps;
  import pih_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KEY_W-1:0]  lookup_key = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  entry_index;
  logic [1:0]        outcome;

  pointer_intern_hash_table dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .lookup_key(lookup_key), .out_valid(out_valid), .out_stall(out_stall),
    .entry_index(entry_index), .outcome(outcome)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state
  logic [KEY_W-1:0] map_key [MAP_DEPTH];
  logic [IDX_W-1:0] map_idx [MAP_DEPTH];
  logic [KEY_W-1:0] interned [LIST_DEPTH];
  int unsigned      n_interned;
  int unsigned      map_exp;
  bit               map_full;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    outcome_t         oc;
  } intern_res_t;

  intern_res_t pending_results[$];
  logic [KEY_W-1:0] known_keys[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit quiet_in = 0, quiet_out = 0;

  function automatic logic [31:0] key_hash(logic [63:0] k);
    logic [31:0] x;
    x = k[31:0] ^ k[63:32];
    x = x ^ (x >> 16);
    x = x * 32'h21f0aaad;
    x = x ^ (x >> 15);
    x = x * 32'hd35a2d97;
    x = x ^ (x >> 15);
    return x;
  endfunction

  // Double-hash probe; returns slot of match or first empty
  function automatic bit find_slot(logic [63:0] k, int unsigned e, output int unsigned pos);
    logic [31:0] h, stp, msk, p;
    h = key_hash(k);
    stp = (h >> (32 - e)) | 32'd1;
    msk = (32'd1 << e) - 1;
    p = h;
    pos = 0;
    for (int n = 0; n < (1 << e); n++) begin
      p = (p + stp) & msk;
      if (map_key[p] == '0 || map_key[p] == k) begin
        pos = p;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void clear_map();
    for (int i = 0; i < MAP_DEPTH; i++) begin
      map_key[i] = '0;
      map_idx[i] = '0;
    end
  endfunction

  function automatic void regrow(int unsigned e);
    int unsigned p;
    clear_map();
    map_exp = e;
    for (int unsigned i = 0; i < n_interned; i++)
      if (find_slot(interned[i], e, p)) begin
        map_key[p] = interned[i];
        map_idx[p] = i[IDX_W-1:0];
      end
  endfunction

  function automatic intern_res_t intern_key(logic [63:0] k);
    intern_res_t r;
    int unsigned p;
    r.idx = '0;
    if (k == '0) begin
      r.oc = OUT_NULL;
      return r;
    end
    if (!find_slot(k, map_exp, p)) begin
      r.oc = OUT_FULL;
      return r;
    end
    if (map_key[p] == k) begin
      r.idx = map_idx[p];
      r.oc = OUT_FOUND;
      return r;
    end
    if (map_full || n_interned >= LIST_DEPTH) begin
      map_full = 1;
      r.oc = OUT_FULL;
      return r;
    end
    map_key[p] = k;
    map_idx[p] = n_interned[IDX_W-1:0];
    interned[n_interned] = k;
    r.idx = n_interned[IDX_W-1:0];
    r.oc = OUT_NEW;
    n_interned++;
    known_keys.push_back(k);
    if (n_interned == (3 << (map_exp - 3))) begin
      if (map_exp < MAX_EXP) regrow(map_exp + 1);
      else map_full = 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one transaction; table rows may carry a hard expectation.
  // Valid stays high into the next transaction unless the sender idles.
  task automatic send_key(logic [63:0] k, bit typed = 0,
                          intern_res_t want = '0);
    intern_res_t r;
    while (!quiet_in && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    lookup_key <= k;
    r = intern_key(k);
    if (typed && r != want) report_mismatch("table row", int'(r), int'(want));
    pending_results.push_back(r);
    do @(posedge clk); while (in_stall);
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", int'(entry_index), 0);
        end else begin
          intern_res_t w;
          w = pending_results.pop_front();
          if (entry_index !== w.idx)
            report_mismatch("entry_index", int'(entry_index), int'(w.idx));
          if (outcome !== w.oc) report_mismatch("outcome", int'(outcome), int'(w.oc));
        end
      end
      out_stall <= !quiet_out && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_pointer_intern_hash_table failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  typedef struct {
    logic [63:0] k;
    bit          typed;
    intern_res_t want;
  } table_row_t;

  table_row_t rows[$];

  initial begin
    int nsent;
    int wait_n;
    n_interned = 0;
    map_exp = INIT_EXP;
    map_full = 0;
    clear_map();
    rows = '{
      '{64'h0, 1, '{11'd0, OUT_NULL}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1, '{11'd0, OUT_NEW}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1, '{11'd0, OUT_FOUND}},
      '{64'h1, 1, '{11'd1, OUT_NEW}},
      '{64'h8000_0000_0000_0000, 1, '{11'd2, OUT_NEW}},
      '{64'h0, 1, '{11'd0, OUT_NULL}},
      '{64'h1, 1, '{11'd1, OUT_FOUND}},
      '{64'h0000_0001_0000_0001, 0, '0},
      '{64'hAAAA_AAAA_5555_5555, 0, '0},
      '{64'h5555_5555_AAAA_AAAA, 0, '0},
      '{64'h0000_0000_FFFF_FFFF, 0, '0},
      '{64'hFFFF_FFFF_0000_0000, 0, '0},
      '{64'hAAAA_AAAA_5555_5555, 0, '0}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed table
    foreach (rows[i]) send_key(rows[i].k, rows[i].typed, rows[i].want);
    // Random part: mostly new keys to drive growth, plus repeats
    // and nulls; a stretch with both sides always ready.
    nsent = 0;
    while (nsent < 1000) begin
      int sel;
      quiet_in = (nsent >= 300 && nsent < 450);
      quiet_out = quiet_in;
      sel = $urandom_range(99);
      if (sel < 4) send_key('0);
      else if (sel < 40 && known_keys.size() > 0)
        send_key(known_keys[$urandom_range(known_keys.size() - 1)]);
      else if (sel < 43) send_key(64'(1) << $urandom_range(63));
      else send_key(rand_key());
      nsent++;
    end
    // A few more lookups of stored keys and new keys at the end
    repeat (40) begin
      send_key(known_keys[$urandom_range(known_keys.size() - 1)]);
      send_key(rand_key());
    end
    in_valid <= 1'b0;
    wait_n = 0;
    while (pending_results.size() != 0 && wait_n < 200000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_pointer_intern_hash_table passed");
    end else begin
      $display("tb_pointer_intern_hash_table failed");
    end
    $finish;
  end
endmodule
